// ----- rtl/text_console_writer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property forms for the console engine checks.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console check failed");

// next-cycle implication, disabled during reset
`define TCW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("console check failed");

`endif

// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Geometry, field widths, character codes, state and decode plan types.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // screen and memory geometry
   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int MEM_CELLS    = 8192;
   localparam int SCREEN_CELLS = COLUMNS * ROWS;

   // field widths
   localparam int CELL_W  = $clog2(MEM_CELLS);
   localparam int COL_W   = $clog2(COLUMNS + 1);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int DATA_W  = 16;
   localparam int ATTR_W  = 8;
   localparam int CHAR_W  = 8;
   localparam int ACT_W   = 2;
   localparam int CSR_W   = 1;
   localparam int CPY_W   = $clog2(SCREEN_CELLS + 1);
   localparam int BLK_W   = $clog2(COLUMNS);
   localparam int SUM_W   = $clog2(MEM_CELLS + SCREEN_CELLS + COLUMNS + 1);

   // reset values of the control registers
   localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
   localparam logic [DATA_W-1:0] BLANK_RESET = 16'h0720;

   // actions
   localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

   // control register indexes
   localparam logic [CSR_W-1:0] CSR_CHAR_ATTR = 1'd0;
   localparam logic [CSR_W-1:0] CSR_BLANK     = 1'd1;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CH_ENQ = 8'h05;
   localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;
   localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_BLANK,
      ST_PUT
   } state_type;

   // what one accepted beat does, decided in the idle cycle
   typedef struct packed {
      logic              wr_en;
      logic [CELL_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [CELL_W-1:0] cur;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              scroll;
      logic              copy;
      logic              put_after;
      logic              rd_en;
      logic              clear;
   } plan_type;

endpackage

// ----- rtl/tcw_if.sv -----
// ----------------------------------------------------------------------------
// Text console writer channels
// Request, response and control register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   logic                         valid;
   logic                         ready;
   logic [tcw_pkg::ACT_W-1:0]    action;
   logic [tcw_pkg::CHAR_W-1:0]   char_code;
   logic [tcw_pkg::CELL_W-1:0]   read_cell;

   modport source (output valid, action, char_code, read_cell, input ready);
   modport sink   (input valid, action, char_code, read_cell, output ready);
endinterface

interface tcw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tcw_pkg::CELL_W-1:0]   cursor_cell;
   logic [tcw_pkg::CELL_W-1:0]   screen_start;
   logic [tcw_pkg::COL_W-1:0]    cursor_column;
   logic [tcw_pkg::ROW_W-1:0]    cursor_row;
   logic [tcw_pkg::DATA_W-1:0]   read_data;

   modport source (output valid, cursor_cell, screen_start, cursor_column, cursor_row,
                   read_data, input ready);
   modport sink   (input valid, cursor_cell, screen_start, cursor_column, cursor_row,
                   read_data, output ready);
endinterface

interface tcw_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tcw_pkg::CSR_W-1:0]    reg_index;
   logic [tcw_pkg::DATA_W-1:0]   wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- rtl/tcw_decode.sv -----
// ----------------------------------------------------------------------------
// Text console writer decode
// Interprets one request beat against the cursor state: next cursor values,
// the single cell write it needs, and whether a scroll sequence follows.
// ----------------------------------------------------------------------------
module tcw_decode (
   input  logic [tcw_pkg::ACT_W-1:0]  action,
   input  logic [tcw_pkg::CHAR_W-1:0] char_code,
   input  logic [tcw_pkg::CELL_W-1:0] cur,
   input  logic [tcw_pkg::CELL_W-1:0] win,
   input  logic [tcw_pkg::COL_W-1:0]  col,
   input  logic [tcw_pkg::ROW_W-1:0]  row,
   input  logic [tcw_pkg::ATTR_W-1:0] char_attr,
   input  logic [tcw_pkg::DATA_W-1:0] blank,
   output tcw_pkg::plan_type          plan
);

   localparam logic [tcw_pkg::CELL_W-1:0] COLS_CELL = tcw_pkg::CELL_W'(tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::COL_W-1:0]  COLS_COL  = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
   localparam logic [tcw_pkg::SUM_W-1:0]  SCROLL_SPAN =
      tcw_pkg::SUM_W'(tcw_pkg::SCREEN_CELLS + tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::SUM_W-1:0]  MEM_LIMIT = tcw_pkg::SUM_W'(tcw_pkg::MEM_CELLS);

   logic                         last_row;
   logic [tcw_pkg::CELL_W-1:0]   cr_cur;
   logic [tcw_pkg::DATA_W-1:0]   glyph;
   logic                         near_end;

   // shared terms
   assign last_row = (row == LAST_ROW);
   assign cr_cur   = cur - tcw_pkg::CELL_W'(col);
   assign glyph    = {char_attr, char_code};
   assign near_end = ({{(tcw_pkg::SUM_W - tcw_pkg::CELL_W){1'b0}}, win} + SCROLL_SPAN)
                     >= MEM_LIMIT;

   // beat interpretation
   always_comb begin
      plan           = '0;
      plan.cur       = cur;
      plan.col       = col;
      plan.row       = row;
      plan.wr_addr   = cur;
      plan.wr_data   = blank;
      unique case (action)
         tcw_pkg::ACT_WRITE: begin
            unique case (char_code) inside
               tcw_pkg::CH_NUL, tcw_pkg::CH_ENQ, tcw_pkg::CH_BEL,
               tcw_pkg::CH_TAB, tcw_pkg::CH_VT, tcw_pkg::CH_ESC: begin
               end
               tcw_pkg::CH_BS: begin
                  if (col != '0) begin
                     plan.col     = col - tcw_pkg::COL_W'(1);
                     plan.cur     = cur - tcw_pkg::CELL_W'(1);
                     plan.wr_en   = 1'b1;
                     plan.wr_addr = cur - tcw_pkg::CELL_W'(1);
                  end
               end
               tcw_pkg::CH_LF: begin
                  plan.col = '0;
                  if (last_row) begin
                     plan.scroll = 1'b1;
                     plan.cur    = cr_cur;
                  end else begin
                     plan.row = row + tcw_pkg::ROW_W'(1);
                     plan.cur = cr_cur + COLS_CELL;
                  end
               end
               tcw_pkg::CH_FF: begin
                  if (last_row) begin
                     plan.scroll = 1'b1;
                  end else begin
                     plan.row = row + tcw_pkg::ROW_W'(1);
                     plan.cur = cur + COLS_CELL;
                  end
               end
               tcw_pkg::CH_CR: begin
                  plan.cur = cr_cur;
                  plan.col = '0;
               end
               tcw_pkg::CH_DEL: begin
                  plan.wr_en = 1'b1;
               end
               default: begin
                  plan.wr_data = glyph;
                  if (col >= COLS_COL) begin
                     // pending wrap: move to the next line first
                     if (last_row) begin
                        plan.scroll    = 1'b1;
                        plan.put_after = 1'b1;
                        plan.cur       = cr_cur;
                        plan.col       = '0;
                     end else begin
                        plan.row     = row + tcw_pkg::ROW_W'(1);
                        plan.wr_en   = 1'b1;
                        plan.wr_addr = cr_cur + COLS_CELL;
                        plan.cur     = cr_cur + COLS_CELL + tcw_pkg::CELL_W'(1);
                        plan.col     = tcw_pkg::COL_W'(1);
                     end
                  end else begin
                     plan.wr_en = 1'b1;
                     plan.cur   = cur + tcw_pkg::CELL_W'(1);
                     plan.col   = col + tcw_pkg::COL_W'(1);
                  end
               end
            endcase
         end
         tcw_pkg::ACT_CLEAR: plan.clear = 1'b1;
         tcw_pkg::ACT_READ:  plan.rd_en = 1'b1;
         default: begin
         end
      endcase
      plan.copy = plan.scroll && near_end;
   end

endmodule

// ----- rtl/text_console_writer_top.sv -----
// ----------------------------------------------------------------------------
// Text console writer top: plain beats respond in the cycle after accept, one a cycle while each
// response is taken; reads pass the READ state. Scroll blanks a row in BLANK, after the COPY of
// the screen near the end of memory; a wrapped print adds PUT. Clear writes every cell through the
// single RAM write port; so does reset, with no beats accepted. CSR writes are taken always.
// ----------------------------------------------------------------------------
`include "text_console_writer_top_defines.svh"

module text_console_writer_top (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_ch,
   tcw_rsp_if.source rsp_ch,
   tcw_csr_if.sink   csr_ch
);

   localparam logic [tcw_pkg::CELL_W-1:0] COLS_CELL   = tcw_pkg::CELL_W'(tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::CELL_W-1:0] SCREEN_CELL =
      tcw_pkg::CELL_W'(tcw_pkg::SCREEN_CELLS);
   localparam logic [tcw_pkg::CPY_W-1:0]  CPY_LAST    = tcw_pkg::CPY_W'(tcw_pkg::SCREEN_CELLS);
   localparam logic [tcw_pkg::BLK_W-1:0]  BLK_LAST    = tcw_pkg::BLK_W'(tcw_pkg::COLUMNS - 1);

   // sequencer and cursor state
   tcw_pkg::state_type           state_ff, state_in;
   logic [tcw_pkg::CELL_W-1:0]   cur_ff;
   logic [tcw_pkg::CELL_W-1:0]   win_ff;
   logic [tcw_pkg::COL_W-1:0]    col_ff;
   logic [tcw_pkg::ROW_W-1:0]    row_ff;
   logic [tcw_pkg::ATTR_W-1:0]   attr_ff;
   logic [tcw_pkg::DATA_W-1:0]   blank_ff;
   logic [tcw_pkg::CELL_W-1:0]   clr_cnt_ff;
   logic                         clr_resp_ff;
   logic [tcw_pkg::CPY_W-1:0]    cpy_cnt_ff;
   logic [tcw_pkg::BLK_W-1:0]    blk_cnt_ff;
   logic                         put_ff;
   logic [tcw_pkg::DATA_W-1:0]   put_data_ff;
   logic                         rsp_valid_ff;
   logic [tcw_pkg::DATA_W-1:0]   read_data_ff;

   // cell memory
   logic [tcw_pkg::DATA_W-1:0]   mem [tcw_pkg::MEM_CELLS];
   logic [tcw_pkg::DATA_W-1:0]   mem_rdata_ff;
   logic                         mem_we;
   logic [tcw_pkg::CELL_W-1:0]   mem_waddr;
   logic [tcw_pkg::DATA_W-1:0]   mem_wdata;
   logic                         mem_re;
   logic [tcw_pkg::CELL_W-1:0]   mem_raddr;

   logic                         req_fire;
   logic                         req_slow;
   logic                         done;
   logic                         done_rd;
   logic                         clr_last;
   logic                         cpy_last;
   logic                         blk_last;
   tcw_pkg::plan_type            plan;

   // beat decode
   tcw_decode u_decode (
      .action    (req_ch.action),
      .char_code (req_ch.char_code),
      .cur       (cur_ff),
      .win       (win_ff),
      .col       (col_ff),
      .row       (row_ff),
      .char_attr (attr_ff),
      .blank     (blank_ff),
      .plan      (plan)
   );

   // handshakes
   assign req_ch.ready = (state_ff == tcw_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_slow     = plan.clear || plan.rd_en || plan.scroll;
   assign csr_ch.ready = 1'b1;

   // response: cursor fields stay put while a response waits
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.cursor_cell   = cur_ff;
   assign rsp_ch.screen_start  = win_ff;
   assign rsp_ch.cursor_column = col_ff;
   assign rsp_ch.cursor_row    = row_ff;
   assign rsp_ch.read_data     = read_data_ff;

   assign clr_last = &clr_cnt_ff;
   assign cpy_last = (cpy_cnt_ff == CPY_LAST);
   assign blk_last = (blk_cnt_ff == BLK_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: if (clr_last) state_in = tcw_pkg::ST_IDLE;
         tcw_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (plan.clear)       state_in = tcw_pkg::ST_CLEAR;
               else if (plan.rd_en)  state_in = tcw_pkg::ST_READ;
               else if (plan.copy)   state_in = tcw_pkg::ST_COPY;
               else if (plan.scroll) state_in = tcw_pkg::ST_BLANK;
            end
         end
         tcw_pkg::ST_READ:  state_in = tcw_pkg::ST_IDLE;
         tcw_pkg::ST_COPY:  if (cpy_last) state_in = tcw_pkg::ST_BLANK;
         tcw_pkg::ST_BLANK: begin
            if (blk_last) state_in = put_ff ? tcw_pkg::ST_PUT : tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_PUT:   state_in = tcw_pkg::ST_IDLE;
         default:           state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // memory port control and completion
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_ff;
      mem_wdata = blank_ff;
      mem_re    = 1'b0;
      mem_raddr = req_ch.read_cell;
      done      = 1'b0;
      done_rd   = 1'b0;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = clr_resp_ff ? blank_ff : tcw_pkg::BLANK_RESET;
            done      = clr_last && clr_resp_ff;
         end
         tcw_pkg::ST_IDLE: begin
            mem_we    = req_fire && plan.wr_en;
            mem_waddr = plan.wr_addr;
            mem_wdata = plan.wr_data;
            mem_re    = req_fire && plan.rd_en;
            done      = req_fire && !req_slow;
         end
         tcw_pkg::ST_READ: begin
            done    = 1'b1;
            done_rd = 1'b1;
         end
         tcw_pkg::ST_COPY: begin
            // read one cell ahead of the write back to the base
            mem_re    = !cpy_last;
            mem_raddr = win_ff + tcw_pkg::CELL_W'(cpy_cnt_ff);
            mem_we    = (cpy_cnt_ff != '0);
            mem_waddr = tcw_pkg::CELL_W'(cpy_cnt_ff - tcw_pkg::CPY_W'(1));
            mem_wdata = mem_rdata_ff;
         end
         tcw_pkg::ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = win_ff + SCREEN_CELL + tcw_pkg::CELL_W'(blk_cnt_ff);
            done      = blk_last && !put_ff;
         end
         tcw_pkg::ST_PUT: begin
            mem_we    = 1'b1;
            mem_wdata = put_data_ff;
            done      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // cell memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (done) begin
         read_data_ff <= done_rd ? mem_rdata_ff : '0;
      end
      if (req_fire) begin
         put_data_ff <= plan.wr_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_CLEAR;
         cur_ff       <= '0;
         win_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         blank_ff     <= tcw_pkg::BLANK_RESET;
         clr_cnt_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         cpy_cnt_ff   <= '0;
         blk_cnt_ff   <= '0;
         put_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // register writes
         if (csr_ch.valid) begin
            case (csr_ch.reg_index)
               tcw_pkg::CSR_CHAR_ATTR: attr_ff  <= csr_ch.wr_data[tcw_pkg::ATTR_W-1:0];
               tcw_pkg::CSR_BLANK:     blank_ff <= csr_ch.wr_data;
               default: begin
               end
            endcase
         end

         // response slot
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // sequencer side effects
         case (state_ff)
            tcw_pkg::ST_CLEAR: clr_cnt_ff <= clr_cnt_ff + tcw_pkg::CELL_W'(1);
            tcw_pkg::ST_IDLE: begin
               if (req_fire) begin
                  cpy_cnt_ff <= '0;
                  blk_cnt_ff <= '0;
                  clr_cnt_ff <= '0;
                  put_ff     <= plan.put_after;
                  if (plan.clear) begin
                     clr_resp_ff <= 1'b1;
                     cur_ff      <= '0;
                     win_ff      <= '0;
                     col_ff      <= '0;
                     row_ff      <= '0;
                  end else begin
                     cur_ff <= plan.cur;
                     col_ff <= plan.col;
                     row_ff <= plan.row;
                  end
               end
            end
            tcw_pkg::ST_COPY: begin
               cpy_cnt_ff <= cpy_cnt_ff + tcw_pkg::CPY_W'(1);
               if (cpy_last) begin
                  cur_ff <= cur_ff - win_ff;
                  win_ff <= '0;
               end
            end
            tcw_pkg::ST_BLANK: begin
               blk_cnt_ff <= blk_cnt_ff + tcw_pkg::BLK_W'(1);
               if (blk_last) begin
                  win_ff <= win_ff + COLS_CELL;
                  cur_ff <= cur_ff + COLS_CELL;
               end
            end
            tcw_pkg::ST_PUT: begin
               cur_ff <= cur_ff + tcw_pkg::CELL_W'(1);
               col_ff <= col_ff + tcw_pkg::COL_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   // checks
   `TCW_ASSERT_IMP(a_cursor_layout, clock, reset, state_ff == tcw_pkg::ST_IDLE,
      cur_ff == win_ff + tcw_pkg::CELL_W'(row_ff) * COLS_CELL + tcw_pkg::CELL_W'(col_ff))
   `TCW_ASSERT_NXT(a_stall_holds_state, clock, reset, rsp_valid_ff && !rsp_ch.ready,
      $stable(cur_ff) && $stable(win_ff) && $stable(read_data_ff))
   `TCW_ASSERT_NXT(a_quick_beat_done, clock, reset, req_fire && !req_slow, rsp_valid_ff)
   `TCW_ASSERT_IMP(a_busy_no_pending_rsp, clock, reset, state_ff != tcw_pkg::ST_IDLE,
      !rsp_valid_ff)

endmodule

// ----- test/text_console_writer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends character, clear, read and unused-action beats to the console engine.
// A shadow of the cell memory, cursor, row, column and window start predicts
// each status beat, which is checked field by field. Covers line wrap, the
// scroll that copies the screen back to cell 0, and several register settings.
// ----------------------------------------------------------------------------
module text_console_writer_top_test;

   localparam int CYCLE_LIMIT   = 3_000_000;
   // busy time of a scroll with the screen copy; a clear runs longer
   localparam int SETTLE_CYCLES = tcw_pkg::SCREEN_CELLS + tcw_pkg::COLUMNS + 8;
   // action code the engine ignores
   localparam logic [tcw_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [tcw_pkg::CELL_W-1:0] cursor_cell;
      logic [tcw_pkg::CELL_W-1:0] screen_start;
      logic [tcw_pkg::COL_W-1:0]  cursor_column;
      logic [tcw_pkg::ROW_W-1:0]  cursor_row;
      logic [tcw_pkg::DATA_W-1:0] read_data;
   } console_status_type;

   logic clock = 1'b0;
   logic reset;

   tcw_req_if req_ch();
   tcw_rsp_if rsp_ch();
   tcw_csr_if csr_ch();

   text_console_writer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow of the console state
   logic [tcw_pkg::DATA_W-1:0] shadow_cells [tcw_pkg::MEM_CELLS];
   int unsigned                cur_cell;
   int unsigned                view_start;
   int unsigned                cur_col;
   int unsigned                cur_row;
   logic [tcw_pkg::ATTR_W-1:0] attr_reg;
   logic [tcw_pkg::DATA_W-1:0] blank_reg;
   int unsigned                screen_copies = 0;

   console_status_type status_q [$];
   int                 send_idle_pct = 0;
   int                 sink_idle_pct = 0;
   int                 error_count   = 0;
   int                 cycle_count   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- shadow model

   function automatic int unsigned cell_add(int unsigned a, int unsigned b);
      return (a + b) % tcw_pkg::MEM_CELLS;
   endfunction

   function automatic int unsigned cell_sub(int unsigned a, int unsigned b);
      return (a % tcw_pkg::MEM_CELLS + tcw_pkg::MEM_CELLS - b % tcw_pkg::MEM_CELLS)
             % tcw_pkg::MEM_CELLS;
   endfunction

   function void wipe_console();
      view_start = 0;
      cur_cell   = 0;
      cur_col    = 0;
      cur_row    = 0;
      foreach (shadow_cells[i]) shadow_cells[i] = blank_reg;
   endfunction

   // window moves down one row; near the end of memory the screen goes back to 0
   function void scroll_view();
      if (view_start + tcw_pkg::SCREEN_CELLS + tcw_pkg::COLUMNS >= tcw_pkg::MEM_CELLS) begin
         for (int i = 0; i < tcw_pkg::SCREEN_CELLS; i++)
            shadow_cells[i] = shadow_cells[cell_add(view_start, i)];
         cur_cell   = cell_sub(cur_cell, view_start);
         view_start = 0;
         screen_copies++;
      end
      for (int i = 0; i < tcw_pkg::COLUMNS; i++)
         shadow_cells[cell_add(view_start, tcw_pkg::SCREEN_CELLS + i)] = blank_reg;
      view_start = cell_add(view_start, tcw_pkg::COLUMNS);
      cur_cell   = cell_add(cur_cell, tcw_pkg::COLUMNS);
   endfunction

   function void advance_line();
      if (cur_row + 1 < tcw_pkg::ROWS) begin
         cur_row++;
         cur_cell = cell_add(cur_cell, tcw_pkg::COLUMNS);
      end else begin
         scroll_view();
      end
   endfunction

   function void return_carriage();
      cur_cell = cell_sub(cur_cell, cur_col);
      cur_col  = 0;
   endfunction

   function void apply_char(logic [tcw_pkg::CHAR_W-1:0] ch);
      case (ch)
         tcw_pkg::CH_NUL, tcw_pkg::CH_ENQ, tcw_pkg::CH_BEL, tcw_pkg::CH_TAB,
         tcw_pkg::CH_VT, tcw_pkg::CH_ESC: ;
         tcw_pkg::CH_BS: begin
            if (cur_col != 0) begin
               cur_col--;
               cur_cell = cell_sub(cur_cell, 1);
               shadow_cells[cur_cell] = blank_reg;
            end
         end
         tcw_pkg::CH_LF: begin
            advance_line();
            return_carriage();
         end
         tcw_pkg::CH_FF:  advance_line();
         tcw_pkg::CH_CR:  return_carriage();
         tcw_pkg::CH_DEL: shadow_cells[cur_cell] = blank_reg;
         default: begin
            // pending wrap is resolved by the next printed byte
            if (cur_col >= tcw_pkg::COLUMNS) begin
               cur_col -= tcw_pkg::COLUMNS;
               cur_cell = cell_sub(cur_cell, tcw_pkg::COLUMNS);
               advance_line();
            end
            shadow_cells[cur_cell] = {attr_reg, ch};
            cur_cell = cell_add(cur_cell, 1);
            cur_col++;
         end
      endcase
   endfunction

   function console_status_type step_console(logic [tcw_pkg::ACT_W-1:0]  act,
                                             logic [tcw_pkg::CHAR_W-1:0] ch,
                                             logic [tcw_pkg::CELL_W-1:0] rc);
      console_status_type         st;
      logic [tcw_pkg::DATA_W-1:0] rd;
      rd = '0;
      case (act)
         tcw_pkg::ACT_WRITE: apply_char(ch);
         tcw_pkg::ACT_CLEAR: wipe_console();
         tcw_pkg::ACT_READ:  rd = shadow_cells[rc];
         default: ;
      endcase
      st.cursor_cell   = cur_cell[tcw_pkg::CELL_W-1:0];
      st.screen_start  = view_start[tcw_pkg::CELL_W-1:0];
      st.cursor_column = cur_col[tcw_pkg::COL_W-1:0];
      st.cursor_row    = cur_row[tcw_pkg::ROW_W-1:0];
      st.read_data     = rd;
      return st;
   endfunction

   // ---------------------------------------------------------------- checking

   task report_mismatch(string what);
      $display("ERROR @%0t: %s", $time, what);
      error_count++;
   endtask

   task compare_field(string name, logic [tcw_pkg::DATA_W-1:0] got,
                      logic [tcw_pkg::DATA_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   task check_status();
      console_status_type want;
      if (status_q.size() == 0) begin
         report_mismatch("status beat with nothing expected");
      end else begin
         want = status_q.pop_front();
         compare_field("cursor_cell", tcw_pkg::DATA_W'(rsp_ch.cursor_cell),
                       tcw_pkg::DATA_W'(want.cursor_cell));
         compare_field("screen_start", tcw_pkg::DATA_W'(rsp_ch.screen_start),
                       tcw_pkg::DATA_W'(want.screen_start));
         compare_field("cursor_column", tcw_pkg::DATA_W'(rsp_ch.cursor_column),
                       tcw_pkg::DATA_W'(want.cursor_column));
         compare_field("cursor_row", tcw_pkg::DATA_W'(rsp_ch.cursor_row),
                       tcw_pkg::DATA_W'(want.cursor_row));
         compare_field("read_data", rsp_ch.read_data, want.read_data);
      end
   endtask

   // status receiver with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_status();
         rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // ---------------------------------------------------------------- driving

   // one request beat; returns at the edge where it was taken
   task send_item(logic [tcw_pkg::ACT_W-1:0] act, logic [tcw_pkg::CHAR_W-1:0] ch,
                  logic [tcw_pkg::CELL_W-1:0] rc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.char_code <= ch;
      req_ch.read_cell <= rc;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      status_q.push_back(step_console(act, ch, rc));
   endtask

   task send_char(logic [tcw_pkg::CHAR_W-1:0] ch);
      send_item(tcw_pkg::ACT_WRITE, ch,
                tcw_pkg::CELL_W'($urandom_range(tcw_pkg::MEM_CELLS - 1)));
   endtask

   task send_read(int unsigned cell_idx);
      send_item(tcw_pkg::ACT_READ, tcw_pkg::CHAR_W'($urandom_range(255)),
                tcw_pkg::CELL_W'(cell_idx % tcw_pkg::MEM_CELLS));
   endtask

   function automatic bit is_special(logic [tcw_pkg::CHAR_W-1:0] ch);
      case (ch)
         tcw_pkg::CH_NUL, tcw_pkg::CH_ENQ, tcw_pkg::CH_BEL, tcw_pkg::CH_BS,
         tcw_pkg::CH_TAB, tcw_pkg::CH_LF, tcw_pkg::CH_VT, tcw_pkg::CH_FF,
         tcw_pkg::CH_CR, tcw_pkg::CH_ESC, tcw_pkg::CH_DEL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [tcw_pkg::CHAR_W-1:0] random_printable();
      logic [tcw_pkg::CHAR_W-1:0] ch;
      do ch = tcw_pkg::CHAR_W'($urandom_range(255)); while (is_special(ch));
      return ch;
   endfunction

   function automatic logic [tcw_pkg::CHAR_W-1:0] random_quiet_code();
      case ($urandom_range(5))
         0: return tcw_pkg::CH_NUL;
         1: return tcw_pkg::CH_ENQ;
         2: return tcw_pkg::CH_BEL;
         3: return tcw_pkg::CH_TAB;
         4: return tcw_pkg::CH_VT;
         default: return tcw_pkg::CH_ESC;
      endcase
   endfunction

   // stop sending, wait for every status beat and for the engine to settle
   task wait_console_idle();
      req_ch.valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_register(logic [tcw_pkg::CSR_W-1:0] idx, logic [tcw_pkg::DATA_W-1:0] data);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wr_data   <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         tcw_pkg::CSR_CHAR_ATTR: attr_reg  = data[tcw_pkg::ATTR_W-1:0];
         tcw_pkg::CSR_BLANK:     blank_reg = data;
         default: ;
      endcase
   endtask

   task set_console_registers(logic [tcw_pkg::DATA_W-1:0] attr_word,
                              logic [tcw_pkg::DATA_W-1:0] blank_word);
      wait_console_idle();
      write_register(tcw_pkg::CSR_CHAR_ATTR, attr_word);
      write_register(tcw_pkg::CSR_BLANK, blank_word);
      csr_ch.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // every byte class, reads at the memory ends, unused action, clear
   task test_directed_codes();
      send_char(8'h41);
      send_char(8'hFF);
      send_char(8'h80);
      send_char(8'h01);
      send_char(tcw_pkg::CH_NUL);
      send_char(tcw_pkg::CH_ENQ);
      send_char(tcw_pkg::CH_BEL);
      send_char(tcw_pkg::CH_TAB);
      send_char(tcw_pkg::CH_VT);
      send_char(tcw_pkg::CH_ESC);
      send_char(tcw_pkg::CH_BS);
      send_char(tcw_pkg::CH_DEL);
      send_char(tcw_pkg::CH_CR);
      send_char(tcw_pkg::CH_BS);      // column 0: nothing happens
      send_char(tcw_pkg::CH_LF);
      send_char(tcw_pkg::CH_FF);
      send_read(0);
      send_read(1);
      send_read(tcw_pkg::MEM_CELLS - 1);
      send_item(ACT_UNUSED, 8'hFF, '1);
      send_item(tcw_pkg::ACT_CLEAR, 8'hFF, '1);
      send_read(0);
   endtask

   // fill a row, pending wrap, controls at column 80, then wrap by printing
   task test_line_wrap();
      send_char(tcw_pkg::CH_CR);
      repeat (tcw_pkg::COLUMNS) send_char(random_printable());
      send_read(cell_sub(cur_cell, 1));
      send_char(tcw_pkg::CH_DEL);
      send_char(tcw_pkg::CH_BS);
      send_char(random_printable());
      send_char(tcw_pkg::CH_FF);
      send_char(tcw_pkg::CH_LF);
      repeat (tcw_pkg::COLUMNS - 1) send_char(random_printable());
      send_char(random_printable());
      send_char(random_printable());
      send_read(cell_sub(cur_cell, 2));
   endtask

   // newlines until the window runs into the end of memory and is copied back
   task test_scroll_through_memory();
      int unsigned copies_at_start;
      int          guard;
      copies_at_start = screen_copies;
      guard = 0;
      while (screen_copies == copies_at_start && guard < 300) begin
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(6, 1)) send_char(random_printable());
         send_char($urandom_range(3) == 0 ? tcw_pkg::CH_FF : tcw_pkg::CH_LF);
         guard++;
      end
      repeat (6)
         send_read(cell_add(view_start,
                            $urandom_range(tcw_pkg::SCREEN_CELLS + tcw_pkg::COLUMNS - 1)));
      send_read($urandom_range(tcw_pkg::MEM_CELLS - 1));
      send_read(cell_sub(cur_cell, $urandom_range(tcw_pkg::COLUMNS)));
   endtask

   task test_random_traffic(int count);
      int roll;
      repeat (count) begin
         roll = $urandom_range(999);
         if (roll < 8) begin
            send_item(tcw_pkg::ACT_CLEAR, tcw_pkg::CHAR_W'($urandom_range(255)),
                      tcw_pkg::CELL_W'($urandom_range(tcw_pkg::MEM_CELLS - 1)));
         end else if (roll < 25) begin
            send_item(ACT_UNUSED, tcw_pkg::CHAR_W'($urandom_range(255)),
                      tcw_pkg::CELL_W'($urandom_range(tcw_pkg::MEM_CELLS - 1)));
         end else if (roll < 175) begin
            case ($urandom_range(2))
               0: send_read($urandom_range(tcw_pkg::MEM_CELLS - 1));
               1: send_read(cell_add(view_start,
                     $urandom_range(tcw_pkg::SCREEN_CELLS + tcw_pkg::COLUMNS - 1)));
               default: send_read(cell_sub(cur_cell, $urandom_range(tcw_pkg::COLUMNS)));
            endcase
         end else begin
            roll = $urandom_range(99);
            if (roll < 55)      send_char(random_printable());
            else if (roll < 67) send_char(tcw_pkg::CH_LF);
            else if (roll < 73) send_char(tcw_pkg::CH_FF);
            else if (roll < 79) send_char(tcw_pkg::CH_CR);
            else if (roll < 89) send_char(tcw_pkg::CH_BS);
            else if (roll < 93) send_char(tcw_pkg::CH_DEL);
            else                send_char(random_quiet_code());
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= tcw_pkg::ACT_WRITE;
      req_ch.char_code <= tcw_pkg::CH_NUL;
      req_ch.read_cell <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.reg_index <= tcw_pkg::CSR_CHAR_ATTR;
      csr_ch.wr_data   <= '0;
      attr_reg  = tcw_pkg::ATTR_RESET;
      blank_reg = tcw_pkg::BLANK_RESET;
      wipe_console();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // slow sender, heavily stalled receiver
      send_idle_pct = 19;
      sink_idle_pct = 86;
      test_directed_codes();
      set_console_registers({8'($urandom_range(255)), 8'h00}, 16'h0000);
      test_line_wrap();
      test_scroll_through_memory();
      test_random_traffic(210);

      // bursty sender, mostly ready receiver
      send_idle_pct = 86;
      sink_idle_pct = 19;
      set_console_registers({8'($urandom_range(255)), 8'hFF}, 16'hFFFF);
      test_random_traffic(210);

      // full rate both ways
      send_idle_pct = 0;
      sink_idle_pct = 0;
      set_console_registers(tcw_pkg::DATA_W'($urandom_range(65535)),
                            tcw_pkg::DATA_W'($urandom_range(65535)));
      test_scroll_through_memory();
      test_random_traffic(210);

      wait_console_idle();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_decode.sv
rtl/text_console_writer_top.sv
test/text_console_writer_top_test.sv
